@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the option pricer checkers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BCOP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define BCOP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/bcop_pkg.sv @@
// ---------------------------------------------------------------------------
// bcop_pkg
// Types, constants and command codes of the binomial call option pricer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcop_pkg;

  // lattice size
  localparam int MAX_STEPS = 1024;
  localparam int NODE_DEPTH = MAX_STEPS + 1;
  localparam int ADDR_W = $clog2(NODE_DEPTH);

  // field widths
  localparam int PRICE_W = 32;
  localparam int COEF_W = 32;
  localparam int STEP_W = 11;
  localparam int PROD_W = PRICE_W + COEF_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // fixed point shifts
  localparam int Q30_FRAC = 30;
  localparam int Q32_FRAC = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DISC_UP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISC_DOWN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP_RATIO_SQ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LEAF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 3'd4;

  // configuration reset values
  localparam logic [COEF_W-1:0] RST_DISC_UP = 32'h2000_0000;
  localparam logic [COEF_W-1:0] RST_DISC_DOWN = 32'h2000_0000;
  localparam logic [COEF_W-1:0] RST_UP_RATIO_SQ = 32'h4000_0000;
  localparam logic [COEF_W-1:0] RST_LOW_LEAF = 32'hFFFF_FFFF;
  localparam logic [STEP_W-1:0] RST_STEP_COUNT = 11'd1;

  // datapath command codes
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE = 4'd0;
  localparam logic [OP_W-1:0] OP_START = 4'd1;
  localparam logic [OP_W-1:0] OP_LEAF_MUL = 4'd2;
  localparam logic [OP_W-1:0] OP_LEAF_LOW = 4'd3;
  localparam logic [OP_W-1:0] OP_LEAF_UP = 4'd4;
  localparam logic [OP_W-1:0] OP_RD_FIRST = 4'd5;
  localparam logic [OP_W-1:0] OP_RD_NODE = 4'd6;
  localparam logic [OP_W-1:0] OP_RD_FINAL = 4'd7;
  localparam logic [OP_W-1:0] OP_LOAD_OUT = 4'd8;

  typedef struct packed {
    logic [COEF_W-1:0] disc_up;
    logic [COEF_W-1:0] disc_down;
    logic [COEF_W-1:0] up_ratio_sq;
    logic [COEF_W-1:0] low_leaf_factor;
    logic [STEP_W-1:0] step_count;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ADDR_W-1:0] addr;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_status_t;

endpackage

@@ rtl/bcop_if.sv @@
// ---------------------------------------------------------------------------
// bcop_if
// Request, result and configuration channels of the option pricer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bcop_req_if;
  logic valid;
  logic ready;
  logic [bcop_pkg::PRICE_W-1:0] spot_price;
  logic [bcop_pkg::PRICE_W-1:0] strike_price;

  modport source (output valid, output spot_price, output strike_price, input ready);
  modport sink (input valid, input spot_price, input strike_price, output ready);
endinterface

interface bcop_rsp_if;
  logic valid;
  logic ready;
  logic [bcop_pkg::PRICE_W-1:0] option_value;
  logic saturated;

  modport source (output valid, output option_value, output saturated, input ready);
  modport sink (input valid, input option_value, input saturated, output ready);
endinterface

interface bcop_cfg_if;
  logic valid;
  logic ready;
  logic [bcop_pkg::CFG_IDX_W-1:0] index;
  logic [bcop_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/binomial_call_option_pricer.sv @@
// ---------------------------------------------------------------------------
// binomial_call_option_pricer: binomial lattice European call, one root per item
// Leaves are built in turn on the shared multiplier, a multiply and a store per leaf;
// each fold pass reads and writes the node store once per node, then drains.
// One item at a time: a new item is taken only once the previous one is through,
// though it is taken while the previous result waits.
// Synchronous reset clears control and configuration; the node store is not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module binomial_call_option_pricer (
  input  logic        clk,
  input  logic        rst,
  bcop_req_if.sink    req,
  bcop_rsp_if.source  rsp,
  bcop_cfg_if.sink    cfg
);

  bcop_pkg::cfg_t       regs;
  bcop_pkg::dp_cmd_t    cmd;
  bcop_pkg::dp_status_t status;

  // configuration registers
  bcop_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // sequencer
  bcop_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .step_count (regs.step_count),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // arithmetic and node store
  bcop_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .regs         (regs),
    .cmd          (cmd),
    .spot_price   (req.spot_price),
    .strike_price (req.strike_price),
    .status       (status),
    .option_value (rsp.option_value),
    .saturated    (rsp.saturated)
  );

endmodule

@@ rtl/bcop_ram.sv @@
// ---------------------------------------------------------------------------
// bcop_ram
// Generic simple dual port RAM, one write and one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcop_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

@@ rtl/bcop_cfg.sv @@
// ---------------------------------------------------------------------------
// bcop_cfg
// Configuration register file of the option pricer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcop_cfg (
  input  logic             clk,
  input  logic             rst,
  bcop_cfg_if.sink         cfg,
  output bcop_pkg::cfg_t   regs
);

  logic wr;

  assign cfg.ready = !rst;
  assign wr = cfg.valid && cfg.ready;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.disc_up <= bcop_pkg::RST_DISC_UP;
      regs.disc_down <= bcop_pkg::RST_DISC_DOWN;
      regs.up_ratio_sq <= bcop_pkg::RST_UP_RATIO_SQ;
      regs.low_leaf_factor <= bcop_pkg::RST_LOW_LEAF;
      regs.step_count <= bcop_pkg::RST_STEP_COUNT;
    end else if (wr) begin
      case (cfg.index)
        bcop_pkg::REG_DISC_UP: regs.disc_up <= cfg.data[bcop_pkg::COEF_W-1:0];
        bcop_pkg::REG_DISC_DOWN: regs.disc_down <= cfg.data[bcop_pkg::COEF_W-1:0];
        bcop_pkg::REG_UP_RATIO_SQ: regs.up_ratio_sq <= cfg.data[bcop_pkg::COEF_W-1:0];
        bcop_pkg::REG_LOW_LEAF: regs.low_leaf_factor <= cfg.data[bcop_pkg::COEF_W-1:0];
        bcop_pkg::REG_STEP_COUNT: regs.step_count <= cfg.data[bcop_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/bcop_dp.sv @@
// ---------------------------------------------------------------------------
// bcop_dp
// Datapath: leaf multiplier, fold pipeline, node store and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcop_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  bcop_pkg::cfg_t                  regs,
  input  bcop_pkg::dp_cmd_t               cmd,
  input  logic [bcop_pkg::PRICE_W-1:0]    spot_price,
  input  logic [bcop_pkg::PRICE_W-1:0]    strike_price,
  output bcop_pkg::dp_status_t            status,
  output logic [bcop_pkg::PRICE_W-1:0]    option_value,
  output logic                            saturated
);

  localparam int PW = bcop_pkg::PRICE_W;
  localparam int XW = bcop_pkg::PROD_W;
  localparam int AW = bcop_pkg::ADDR_W;
  localparam int QF = bcop_pkg::Q30_FRAC;
  localparam int LF = bcop_pkg::Q32_FRAC;

  // registers
  logic [XW-1:0] p1;
  logic [XW-1:0] p2;
  logic [PW-1:0] strike_r;
  logic [PW-1:0] leaf;
  logic [PW-1:0] vd;
  logic          flag;
  logic          s1_valid;
  logic          s1_first;
  logic [AW-1:0] s1_wa;
  logic          s2_valid;
  logic [AW-1:0] s2_wa;

  // combinational
  logic [PW-1:0] mul_a;
  logic [PW-1:0] mul_b;
  logic          p1_load;
  logic          s1_node;
  logic          leaf_wr;
  logic          leaf_ovf;
  logic [PW-1:0] leaf_new;
  logic [PW-1:0] leaf_pay;
  logic [XW:0]   fold_sum;
  logic          fold_ovf;
  logic [PW-1:0] fold_val;
  logic          ram_we;
  logic [AW-1:0] ram_wa;
  logic [PW-1:0] ram_wd;
  logic          ram_re;
  logic [AW-1:0] ram_ra;
  logic [PW-1:0] ram_rd;

  assign s1_node = s1_valid && !s1_first;
  assign leaf_wr = (cmd.op == bcop_pkg::OP_LEAF_LOW) || (cmd.op == bcop_pkg::OP_LEAF_UP);
  assign p1_load = (cmd.op == bcop_pkg::OP_START) || (cmd.op == bcop_pkg::OP_LEAF_MUL) ||
                   s1_node;

  // shared multiplier operand select
  always_comb begin
    mul_a = ram_rd;
    mul_b = regs.disc_up;
    unique case (cmd.op)
      bcop_pkg::OP_START: begin
        mul_a = spot_price;
        mul_b = regs.low_leaf_factor;
      end
      bcop_pkg::OP_LEAF_MUL: begin
        mul_a = leaf;
        mul_b = regs.up_ratio_sq;
      end
      default: ;
    endcase
  end

  // leaf price and its payoff
  always_comb begin
    leaf_ovf = (cmd.op == bcop_pkg::OP_LEAF_UP) && (|p1[XW-1:PW+QF]);
    if (cmd.op == bcop_pkg::OP_LEAF_LOW) begin
      leaf_new = p1[LF+PW-1:LF];
    end else if (|p1[XW-1:PW+QF]) begin
      leaf_new = '1;
    end else begin
      leaf_new = p1[PW+QF-1:QF];
    end
    leaf_pay = (leaf_new > strike_r) ? (leaf_new - strike_r) : '0;
  end

  // fold node: exact sum, shift and saturate
  always_comb begin
    fold_sum = {1'b0, p1} + {1'b0, p2};
    fold_ovf = |fold_sum[XW:PW+QF];
    fold_val = fold_ovf ? '1 : fold_sum[PW+QF-1:QF];
  end

  // node store ports
  assign ram_we = leaf_wr || s2_valid;
  assign ram_wa = s2_valid ? s2_wa : cmd.addr;
  assign ram_wd = s2_valid ? fold_val : leaf_pay;
  assign ram_re = (cmd.op == bcop_pkg::OP_RD_FIRST) || (cmd.op == bcop_pkg::OP_RD_NODE) ||
                  (cmd.op == bcop_pkg::OP_RD_FINAL);
  assign ram_ra = (cmd.op == bcop_pkg::OP_RD_NODE) ? (cmd.addr + AW'(1)) : cmd.addr;

  bcop_ram #(
    .WIDTH (PW),
    .DEPTH (bcop_pkg::NODE_DEPTH)
  ) u_nodes (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (ram_re),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  // fold pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      flag <= 1'b0;
      leaf <= '0;
    end else begin
      s1_valid <= (cmd.op == bcop_pkg::OP_RD_FIRST) || (cmd.op == bcop_pkg::OP_RD_NODE);
      s2_valid <= s1_node;
      if (cmd.op == bcop_pkg::OP_START) begin
        flag <= 1'b0;
      end else if (leaf_ovf || (s2_valid && fold_ovf)) begin
        flag <= 1'b1;
      end
      if (leaf_wr) begin
        leaf <= leaf_new;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_first <= (cmd.op == bcop_pkg::OP_RD_FIRST);
    s1_wa <= cmd.addr;
    s2_wa <= s1_wa;
    if (p1_load) begin
      p1 <= mul_a * mul_b;
    end
    if (s1_node) begin
      p2 <= regs.disc_down * vd;
    end
    if (s1_valid) begin
      vd <= ram_rd;
    end
    if (cmd.op == bcop_pkg::OP_START) begin
      strike_r <= strike_price;
    end
    if (cmd.op == bcop_pkg::OP_LOAD_OUT) begin
      option_value <= ram_rd;
      saturated <= flag;
    end
  end

  assign status.busy = s1_valid || s2_valid;

endmodule

@@ rtl/bcop_ctrl.sv @@
// ---------------------------------------------------------------------------
// bcop_ctrl
// Sequencer: leaf build, triangular fold passes and result handoff
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcop_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [bcop_pkg::STEP_W-1:0]    step_count,
  input  logic                           req_valid,
  output logic                           req_ready,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  input  bcop_pkg::dp_status_t           status,
  output bcop_pkg::dp_cmd_t              cmd
);

  localparam int AW = bcop_pkg::ADDR_W;
  localparam int SW = bcop_pkg::STEP_W;
  localparam int CW = (AW > SW) ? AW : SW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LEAF_WR = 3'd1;
  localparam logic [2:0] S_LEAF_MUL = 3'd2;
  localparam logic [2:0] S_FOLD_FIRST = 3'd3;
  localparam logic [2:0] S_FOLD_NODE = 3'd4;
  localparam logic [2:0] S_FOLD_DRAIN = 3'd5;
  localparam logic [2:0] S_FIN_RD = 3'd6;
  localparam logic [2:0] S_FIN_OUT = 3'd7;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [AW-1:0] n;
  logic [AW-1:0] n_next;
  logic [AW-1:0] k;
  logic [AW-1:0] k_next;
  logic [AW-1:0] m;
  logic [AW-1:0] m_next;
  logic [AW-1:0] j;
  logic [AW-1:0] j_next;
  logic          rsp_valid_next;
  logic [AW-1:0] n_clamped;
  logic          out_free;

  // clamp the step count to the store size
  assign n_clamped = (CW'(step_count) > CW'(bcop_pkg::MAX_STEPS)) ?
                     AW'(bcop_pkg::MAX_STEPS) : AW'(step_count);
  assign out_free = !rsp_valid || rsp_ready;
  assign req_ready = !rst && (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    n_next = n;
    k_next = k;
    m_next = m;
    j_next = j;
    cmd.op = bcop_pkg::OP_NONE;
    cmd.addr = '0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op = bcop_pkg::OP_START;
          n_next = n_clamped;
          k_next = '0;
          state_next = S_LEAF_WR;
        end
      end
      S_LEAF_WR: begin
        cmd.op = (k == '0) ? bcop_pkg::OP_LEAF_LOW : bcop_pkg::OP_LEAF_UP;
        cmd.addr = k;
        if (k == n) begin
          m_next = n;
          state_next = (n == '0) ? S_FIN_RD : S_FOLD_FIRST;
        end else begin
          k_next = k + AW'(1);
          state_next = S_LEAF_MUL;
        end
      end
      S_LEAF_MUL: begin
        cmd.op = bcop_pkg::OP_LEAF_MUL;
        state_next = S_LEAF_WR;
      end
      S_FOLD_FIRST: begin
        cmd.op = bcop_pkg::OP_RD_FIRST;
        j_next = '0;
        state_next = S_FOLD_NODE;
      end
      S_FOLD_NODE: begin
        cmd.op = bcop_pkg::OP_RD_NODE;
        cmd.addr = j;
        if (j == m - AW'(1)) begin
          state_next = S_FOLD_DRAIN;
        end else begin
          j_next = j + AW'(1);
        end
      end
      S_FOLD_DRAIN: begin
        // last write of the pass must land before the next pass reads
        if (!status.busy) begin
          m_next = m - AW'(1);
          state_next = (m == AW'(1)) ? S_FIN_RD : S_FOLD_FIRST;
        end
      end
      S_FIN_RD: begin
        cmd.op = bcop_pkg::OP_RD_FINAL;
        state_next = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        if (out_free) begin
          cmd.op = bcop_pkg::OP_LOAD_OUT;
          rsp_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
      n <= '0;
      k <= '0;
      m <= '0;
      j <= '0;
    end else begin
      state <= state_next;
      rsp_valid <= rsp_valid_next;
      n <= n_next;
      k <= k_next;
      m <= m_next;
      j <= j_next;
    end
  end

endmodule

@@ rtl/bcop_checker.sv @@
// ---------------------------------------------------------------------------
// bcop_checker
// Port level checks of the option pricer, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bcop_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [bcop_pkg::PRICE_W-1:0]  option_value,
  input logic                          saturated,
  input logic                          cfg_ready
);

  // an accepted item leaves the block not ready in the next cycle
  `BCOP_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)

  // a result only appears at the end of work, never from the idle state
  `BCOP_ASSERT_NOW(a_result_from_work, clk, rst, $rose(rsp_valid), !$past(req_ready))

  // configuration port is always open out of reset
  `BCOP_ASSERT_NOW(a_cfg_open, clk, rst, 1'b1, cfg_ready)

  // a waiting result stays offered and unchanged
  `BCOP_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `BCOP_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready,
                    $stable(option_value) && $stable(saturated))

endmodule

bind binomial_call_option_pricer bcop_checker u_bcop_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .option_value (rsp.option_value),
  .saturated    (rsp.saturated),
  .cfg_ready    (cfg.ready)
);

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binomial call option pricer. A scoreboard
// class prices each accepted request on its own lattice copy and checks
// every root and saturation flag in order. Stimulus runs a directed pass
// over the corner cases, two full-depth lattices, then random settings and
// random prices. Both channels idle in random bursts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bcop_pkg::*;

  localparam int STALL_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 1200;
  localparam int RANDOM_ITEMS = 85;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_SLOT = '1;

  typedef struct packed {
    logic [PRICE_W-1:0] option_value;
    logic saturated;
  } call_root_t;

  // lattice predictor plus queue of roots still owed by the block
  class call_price_board;
    bit [COEF_W-1:0] disc_up;
    bit [COEF_W-1:0] disc_down;
    bit [COEF_W-1:0] up_ratio_sq;
    bit [COEF_W-1:0] low_leaf_factor;
    bit [STEP_W-1:0] step_count;
    bit [PRICE_W-1:0] nodes [NODE_DEPTH];
    call_root_t pending_roots [$];
    int unsigned mismatches;

    function new();
      disc_up = RST_DISC_UP;
      disc_down = RST_DISC_DOWN;
      up_ratio_sq = RST_UP_RATIO_SQ;
      low_leaf_factor = RST_LOW_LEAF;
      step_count = RST_STEP_COUNT;
      mismatches = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] index, bit [CFG_DATA_W-1:0] data);
      case (index)
        REG_DISC_UP: disc_up = data;
        REG_DISC_DOWN: disc_down = data;
        REG_UP_RATIO_SQ: up_ratio_sq = data;
        REG_LOW_LEAF: low_leaf_factor = data;
        REG_STEP_COUNT: step_count = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [PRICE_W-1:0] intrinsic(bit [PRICE_W-1:0] price, bit [PRICE_W-1:0] strike);
      return (price > strike) ? price - strike : '0;
    endfunction

    // build leaves bottom up, then fold the store in place down to the root
    function call_root_t price_call(bit [PRICE_W-1:0] spot, bit [PRICE_W-1:0] strike);
      call_root_t root;
      bit [PRICE_W-1:0] leaf;
      bit [PROD_W-1:0] grown;
      bit [PROD_W-1:0] up_part;
      bit [PROD_W-1:0] down_part;
      bit [PROD_W:0] folded;
      int depth;
      depth = (step_count > MAX_STEPS) ? MAX_STEPS : int'(step_count);
      root.saturated = 1'b0;
      grown = (PROD_W'(spot) * PROD_W'(low_leaf_factor)) >> Q32_FRAC;
      leaf = grown[PRICE_W-1:0];
      nodes[0] = intrinsic(leaf, strike);
      for (int i = 1; i <= depth; i++) begin
        grown = (PROD_W'(leaf) * PROD_W'(up_ratio_sq)) >> Q30_FRAC;
        if (grown[PROD_W-1:PRICE_W] != 0) begin
          root.saturated = 1'b1;
          leaf = '1;
        end else begin
          leaf = grown[PRICE_W-1:0];
        end
        nodes[i] = intrinsic(leaf, strike);
      end
      for (int i = 0; i < depth; i++) begin
        for (int j = 0; j < depth - i; j++) begin
          up_part = PROD_W'(disc_up) * PROD_W'(nodes[j + 1]);
          down_part = PROD_W'(disc_down) * PROD_W'(nodes[j]);
          folded = ({1'b0, up_part} + {1'b0, down_part}) >> Q30_FRAC;
          if (folded[PROD_W:PRICE_W] != 0) begin
            root.saturated = 1'b1;
            nodes[j] = '1;
          end else begin
            nodes[j] = folded[PRICE_W-1:0];
          end
        end
      end
      root.option_value = nodes[0];
      return root;
    endfunction

    function void note_request(bit [PRICE_W-1:0] spot, bit [PRICE_W-1:0] strike);
      pending_roots.insert(pending_roots.size(), price_call(spot, strike));
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t mismatch: %s", $time, msg);
    endfunction

    function void check_result(logic [PRICE_W-1:0] value, logic sat);
      call_root_t want;
      if (pending_roots.size() == 0) begin
        flag($sformatf("root %h sat %b with no request pending", value, sat));
        return;
      end
      want = pending_roots.pop_front();
      if (want.option_value !== value || want.saturated !== sat)
        flag($sformatf("root expected %h sat %b, got %h sat %b",
                       want.option_value, want.saturated, value, sat));
    endfunction

    function int pending();
      return pending_roots.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit steady_tail;
  int random_items;
  int unsigned idle_cycles = 0;
  call_price_board board;

  bcop_req_if req_ch();
  bcop_rsp_if rsp_ch();
  bcop_cfg_if cfg_ch();

  binomial_call_option_pricer i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: ready in random bursts, steady at the end
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (!steady_tail && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      board.check_result(rsp_ch.option_value, rsp_ch.saturated);
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without progress", idle_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request item; valid is left high for the caller to lower or reuse
  task automatic send_request(input logic [PRICE_W-1:0] spot,
                              input logic [PRICE_W-1:0] strike);
    req_ch.valid <= 1'b1;
    req_ch.spot_price <= spot;
    req_ch.strike_price <= strike;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(spot, strike);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(index, data);
    @(negedge clk);
  endtask

  // full register set, only called with the block idle
  task automatic load_lattice(input logic [COEF_W-1:0] up_coef,
                              input logic [COEF_W-1:0] down_coef,
                              input logic [COEF_W-1:0] ratio_sq,
                              input logic [COEF_W-1:0] low_leaf,
                              input logic [STEP_W-1:0] depth);
    write_reg(REG_DISC_UP, up_coef);
    write_reg(REG_DISC_DOWN, down_coef);
    write_reg(REG_UP_RATIO_SQ, ratio_sq);
    write_reg(REG_LOW_LEAF, low_leaf);
    write_reg(REG_STEP_COUNT, CFG_DATA_W'(depth));
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // hold requests until every owed root is back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
  endtask

  // one random settings phase with a batch of random requests
  task automatic random_phase();
    logic [COEF_W-1:0] up_coef, down_coef, ratio_sq, low_leaf;
    logic [STEP_W-1:0] depth;
    logic [PRICE_W-1:0] spot, strike;
    steady_tail = (random_items >= RANDOM_ITEMS - 15);
    if ($urandom_range(0, 4) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_STEP_COUNT + 1, REG_LAST_SLOT)), $urandom);
    // mostly plausible market coefficients, sometimes anything
    if ($urandom_range(0, 4) < 3) begin
      up_coef = 32'h1C00_0000 + $urandom_range(0, 32'h0600_0000);
      down_coef = 32'h1C00_0000 + $urandom_range(0, 32'h0600_0000);
      ratio_sq = 32'h4000_0000 + $urandom_range(0, 32'h0400_0000);
      low_leaf = $urandom;
    end else begin
      up_coef = $urandom;
      down_coef = $urandom;
      ratio_sq = $urandom;
      low_leaf = $urandom;
    end
    case ($urandom_range(0, 9))
      0: depth = '0;
      1: depth = STEP_W'($urandom_range(17, 40));
      default: depth = STEP_W'($urandom_range(1, 16));
    endcase
    load_lattice(up_coef, down_coef, ratio_sq, low_leaf, depth);
    repeat ($urandom_range(8, 14)) begin
      if (!steady_tail && $urandom_range(0, 3) == 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      case ($urandom_range(0, 5))
        0: begin
          spot = $urandom;
          strike = $urandom;
        end
        1: begin
          spot = $urandom_range(0, 32'h00FF_FFFF);
          strike = spot + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        end
        2: begin
          spot = $urandom_range(0, 1) ? '1 : '0;
          strike = $urandom_range(0, 1) ? '0 : PRICE_W'($urandom);
        end
        default: begin
          spot = $urandom_range(32'h0001_0000, 32'h0200_0000);
          strike = $urandom_range(32'h0001_0000, 32'h0200_0000);
        end
      endcase
      send_request(spot, strike);
      random_items++;
    end
    drain_results();
  endtask

  // main sequence
  initial begin
    board = new();
    steady_tail = 1'b0;
    random_items = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.spot_price <= '0;
    req_ch.strike_price <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, extreme prices
    send_request('0, '0);
    send_request('1, '0);
    send_request('1, '1);
    send_request('0, '1);
    send_request(32'hAAAA_AAAA, 32'h5555_5555);
    send_request(32'h5555_5555, 32'hAAAA_AAAA);
    drain_results();

    // ignored register slot, then a lattice of only the lowest leaf
    write_reg(REG_LAST_SLOT, 32'hDEAD_BEEF);
    load_lattice(RST_DISC_UP, RST_DISC_DOWN, RST_UP_RATIO_SQ, RST_LOW_LEAF, '0);
    send_request('1, 32'h0001_0000);
    send_request(32'h0123_4567, '1);
    drain_results();

    // leaf growth overflow
    load_lattice(RST_DISC_UP, RST_DISC_DOWN, '1, '1, STEP_W'(3));
    send_request('1, '0);
    send_request(32'h0000_0001, '0);
    send_request(32'h0010_0000, 32'h0008_0000);
    drain_results();

    // fold overflow, including a 65-bit sum
    load_lattice('1, '1, RST_UP_RATIO_SQ, RST_LOW_LEAF, STEP_W'(2));
    send_request('1, '0);
    send_request(32'h8000_0000, '0);
    send_request(32'h0000_1000, '0);
    drain_results();

    // zero discounting
    load_lattice('0, '0, RST_UP_RATIO_SQ, RST_LOW_LEAF, STEP_W'(1));
    send_request(32'h1234_5678, '0);
    drain_results();

    // deepest lattice, then a step count clamped to it
    load_lattice(32'h1FF8_0000, 32'h2000_0000, 32'h40D0_0000, 32'h006D_0000,
                 STEP_W'(MAX_STEPS));
    send_request(32'h0064_0000, 32'h0064_0000);
    drain_results();
    load_lattice(32'h1F00_0000, 32'h2080_0000, 32'h4080_0000, 32'h0200_0000, '1);
    send_request(32'h0050_0000, 32'h0048_0000);
    drain_results();

    // random settings and prices
    while (random_items < RANDOM_ITEMS) random_phase();

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (board.pending() != 0) $display("%0d roots never arrived", board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
